### sv/salsa_kg_pkg.sv
// types, register indexes and round functions for the salsa20 keystream generator
package salsa_kg_pkg;

  localparam int WORD_W = 32;
  localparam int NUM_WORDS = 16;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam int DR_W = 4;
  localparam int RND_W = DR_W + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONST_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_D = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DROUNDS = 3'd7;

  localparam logic [DR_W-1:0] DROUNDS_RESET = 4'd10;

  // input kind codes
  localparam logic KIND_GENERATE = 1'b0;
  localparam logic KIND_SET_CTR = 1'b1;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;
  typedef logic [3:0][WORD_W-1:0] quad_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_FEED  = 3'b100
  } fsm_t;

  function automatic logic [WORD_W-1:0] rotl32(logic [WORD_W-1:0] v, int s);
    return (v << s) | (v >> (WORD_W - s));
  endfunction

  // quarter round, returns {d, c, b, a} with a in element 0
  function automatic quad_t quarter(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                                    logic [WORD_W-1:0] c, logic [WORD_W-1:0] d);
    quad_t q;
    logic [WORD_W-1:0] a2, b2, c2, d2;
    b2 = b ^ rotl32(a + d, 7);
    c2 = c ^ rotl32(b2 + a, 9);
    d2 = d ^ rotl32(c2 + b2, 13);
    a2 = a ^ rotl32(d2 + c2, 18);
    q[0] = a2;
    q[1] = b2;
    q[2] = c2;
    q[3] = d2;
    return q;
  endfunction

  function automatic state_t col_round(state_t x);
    state_t y;
    quad_t q0, q1, q2, q3;
    q0 = quarter(x[0], x[4], x[8], x[12]);
    q1 = quarter(x[5], x[9], x[13], x[1]);
    q2 = quarter(x[10], x[14], x[2], x[6]);
    q3 = quarter(x[15], x[3], x[7], x[11]);
    y[0] = q0[0];  y[4] = q0[1];  y[8] = q0[2];  y[12] = q0[3];
    y[5] = q1[0];  y[9] = q1[1];  y[13] = q1[2]; y[1] = q1[3];
    y[10] = q2[0]; y[14] = q2[1]; y[2] = q2[2];  y[6] = q2[3];
    y[15] = q3[0]; y[3] = q3[1];  y[7] = q3[2];  y[11] = q3[3];
    return y;
  endfunction

  // a row round is a column round on the transposed matrix
  function automatic state_t transpose(state_t x);
    state_t y;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        y[4*c+r] = x[4*r+c];
      end
    end
    return y;
  endfunction

  function automatic state_t build_state(logic [CFG_W-1:0] ca, logic [CFG_W-1:0] cb,
                                         logic [CFG_W-1:0] ka, logic [CFG_W-1:0] kb,
                                         logic [CFG_W-1:0] kc, logic [CFG_W-1:0] kd,
                                         logic [CFG_W-1:0] nonce, logic [CFG_W-1:0] ctr);
    state_t s;
    s[0] = ca[31:0];     s[5] = ca[63:32];
    s[10] = cb[31:0];    s[15] = cb[63:32];
    s[1] = ka[31:0];     s[2] = ka[63:32];
    s[3] = kb[31:0];     s[4] = kb[63:32];
    s[11] = kc[31:0];    s[12] = kc[63:32];
    s[13] = kd[31:0];    s[14] = kd[63:32];
    s[6] = nonce[31:0];  s[7] = nonce[63:32];
    s[8] = ctr[31:0];    s[9] = ctr[63:32];
    return s;
  endfunction

  function automatic state_t feed_forward(state_t x, state_t s);
    state_t y;
    for (int i = 0; i < NUM_WORDS; i++) begin
      y[i] = x[i] + s[i];
    end
    return y;
  endfunction

endpackage

### sv/salsa20_keystream_generator.sv
// salsa20 keystream generator: config registers, block counter and shared round unit
// a block takes 2*double_rounds passes of the shared column-round unit, one per cycle,
// then a feed-forward step that waits for the output register to be free
// in_tready is high only when idle: one set-counter transfer per cycle while idle, and a
// new generate transfer only after the last of its BLOCKS_PER_REQUEST blocks is registered;
// output stalls hold the feed-forward step. reset clears the counter, config to defaults
module salsa20_keystream_generator #(
  parameter int BLOCKS_PER_REQUEST = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // counter_value
  input  logic         in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [511:0] out_tdata,  // block_bytes_0 .. block_bytes_7
  output logic         out_tlast   // last_block
);

  localparam int BLK_W = (BLOCKS_PER_REQUEST > 1) ? $clog2(BLOCKS_PER_REQUEST) : 1;
  localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(BLOCKS_PER_REQUEST - 1);

  logic [63:0] const_a_r, const_b_r, key_a_r, key_b_r, key_c_r, key_d_r, nonce_r;
  logic [salsa_kg_pkg::DR_W-1:0] drounds_r;
  logic [63:0] counter_r, counter_nxt;

  salsa_kg_pkg::fsm_t state_r, state_nxt;
  salsa_kg_pkg::state_t x_r, x_nxt, init_words;
  logic [salsa_kg_pkg::RND_W-1:0] rnd_r, rnd_nxt, rnd_last;
  logic [BLK_W-1:0] blk_r, blk_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_last_r, out_last_nxt;
  salsa_kg_pkg::state_t out_data_r, out_data_nxt;

  logic in_xfer, out_free;

  assign in_tready = (state_r == salsa_kg_pkg::ST_IDLE);
  assign in_xfer = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign rnd_last = {drounds_r, 1'b0} - salsa_kg_pkg::RND_W'(1);

  assign init_words = salsa_kg_pkg::build_state(const_a_r, const_b_r, key_a_r, key_b_r,
                                                key_c_r, key_d_r, nonce_r, counter_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      const_a_r <= '0;
      const_b_r <= '0;
      key_a_r <= '0;
      key_b_r <= '0;
      key_c_r <= '0;
      key_d_r <= '0;
      nonce_r <= '0;
      drounds_r <= salsa_kg_pkg::DROUNDS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        salsa_kg_pkg::REG_CONST_A: const_a_r <= cfg_wdata;
        salsa_kg_pkg::REG_CONST_B: const_b_r <= cfg_wdata;
        salsa_kg_pkg::REG_KEY_A: key_a_r <= cfg_wdata;
        salsa_kg_pkg::REG_KEY_B: key_b_r <= cfg_wdata;
        salsa_kg_pkg::REG_KEY_C: key_c_r <= cfg_wdata;
        salsa_kg_pkg::REG_KEY_D: key_d_r <= cfg_wdata;
        salsa_kg_pkg::REG_NONCE: nonce_r <= cfg_wdata;
        salsa_kg_pkg::REG_DROUNDS: drounds_r <= cfg_wdata[salsa_kg_pkg::DR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    counter_nxt = counter_r;
    x_nxt = x_r;
    rnd_nxt = rnd_r;
    blk_nxt = blk_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt = out_last_r;
    out_data_nxt = out_data_r;

    case (state_r)
      salsa_kg_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == salsa_kg_pkg::KIND_SET_CTR) begin
            counter_nxt = in_tdata;
          end else begin
            x_nxt = init_words;
            rnd_nxt = '0;
            blk_nxt = '0;
            state_nxt = (drounds_r == '0) ? salsa_kg_pkg::ST_FEED : salsa_kg_pkg::ST_ROUND;
          end
        end
      end
      salsa_kg_pkg::ST_ROUND: begin
        // shared column-round unit; the transpose turns every second pass into a row round
        x_nxt = salsa_kg_pkg::transpose(salsa_kg_pkg::col_round(x_r));
        rnd_nxt = rnd_r + salsa_kg_pkg::RND_W'(1);
        if (rnd_r == rnd_last) begin
          state_nxt = salsa_kg_pkg::ST_FEED;
        end
      end
      salsa_kg_pkg::ST_FEED: begin
        if (out_free) begin
          out_data_nxt = salsa_kg_pkg::feed_forward(x_r, init_words);
          out_valid_nxt = 1'b1;
          out_last_nxt = (blk_r == BLK_LAST);
          counter_nxt = counter_r + 64'd1;
          if (blk_r == BLK_LAST) begin
            state_nxt = salsa_kg_pkg::ST_IDLE;
          end else begin
            blk_nxt = blk_r + BLK_W'(1);
            rnd_nxt = '0;
            x_nxt = salsa_kg_pkg::build_state(const_a_r, const_b_r, key_a_r, key_b_r,
                                              key_c_r, key_d_r, nonce_r, counter_nxt);
            state_nxt = (drounds_r == '0) ? salsa_kg_pkg::ST_FEED
                                          : salsa_kg_pkg::ST_ROUND;
          end
        end
      end
      default: begin
        state_nxt = salsa_kg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= salsa_kg_pkg::ST_IDLE;
      counter_r <= '0;
      rnd_r <= '0;
      blk_r <= '0;
      out_valid_r <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      counter_r <= counter_nxt;
      rnd_r <= rnd_nxt;
      blk_r <= blk_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### test/salsa20_keystream_generator_test.sv
// self-checking testbench for the salsa20 keystream generator: predictor, scoreboard, stimulus
`timescale 1ns / 1ps

module salsa20_keystream_generator_test;

  localparam int BLOCKS = 4;
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES = 160;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 40;

  // "expand 32-byte k" laid out on the diagonal
  localparam logic [salsa_kg_pkg::CFG_W-1:0] SIGMA_A = {32'h3320646e, 32'h61707865};
  localparam logic [salsa_kg_pkg::CFG_W-1:0] SIGMA_B = {32'h6b206574, 32'h79622d32};

  typedef struct packed {
    logic [511:0] data;
    logic         last;
  } keystream_block_t;

  class keystream_scoreboard;
    logic [salsa_kg_pkg::CFG_W-1:0] reg_file [8];
    logic [63:0]      block_counter;
    logic [31:0]      mix_words [16];
    keystream_block_t pending_blocks [$];
    int               errors;
    int               requests;
    int               counter_loads;
    int               blocks_checked;

    function new();
      foreach (reg_file[i]) reg_file[i] = '0;
      reg_file[salsa_kg_pkg::REG_DROUNDS] =
        salsa_kg_pkg::CFG_W'(salsa_kg_pkg::DROUNDS_RESET);
      block_counter = '0;
      errors = 0;
      requests = 0;
      counter_loads = 0;
      blocks_checked = 0;
    endfunction

    function logic [31:0] rot_left(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter_mix(int a, int b, int c, int d);
      mix_words[b] ^= rot_left(mix_words[a] + mix_words[d], 7);
      mix_words[c] ^= rot_left(mix_words[b] + mix_words[a], 9);
      mix_words[d] ^= rot_left(mix_words[c] + mix_words[b], 13);
      mix_words[a] ^= rot_left(mix_words[d] + mix_words[c], 18);
    endfunction

    function logic [511:0] keystream_block(logic [63:0] ctr);
      logic [31:0]  seed [16];
      logic [511:0] packed_words;
      logic [3:0]   rounds;
      logic [salsa_kg_pkg::CFG_W-1:0] ca, cb, ka, kb, kc, kd, nc;
      rounds = reg_file[salsa_kg_pkg::REG_DROUNDS][3:0];
      ca = reg_file[salsa_kg_pkg::REG_CONST_A];
      cb = reg_file[salsa_kg_pkg::REG_CONST_B];
      ka = reg_file[salsa_kg_pkg::REG_KEY_A];
      kb = reg_file[salsa_kg_pkg::REG_KEY_B];
      kc = reg_file[salsa_kg_pkg::REG_KEY_C];
      kd = reg_file[salsa_kg_pkg::REG_KEY_D];
      nc = reg_file[salsa_kg_pkg::REG_NONCE];
      seed[0]  = ca[31:0];    seed[5]  = ca[63:32];
      seed[10] = cb[31:0];    seed[15] = cb[63:32];
      seed[1]  = ka[31:0];    seed[2]  = ka[63:32];
      seed[3]  = kb[31:0];    seed[4]  = kb[63:32];
      seed[11] = kc[31:0];    seed[12] = kc[63:32];
      seed[13] = kd[31:0];    seed[14] = kd[63:32];
      seed[6]  = nc[31:0];    seed[7]  = nc[63:32];
      seed[8]  = ctr[31:0];   seed[9]  = ctr[63:32];
      foreach (seed[i]) mix_words[i] = seed[i];
      for (int r = 0; r < rounds; r++) begin
        quarter_mix(0, 4, 8, 12);
        quarter_mix(5, 9, 13, 1);
        quarter_mix(10, 14, 2, 6);
        quarter_mix(15, 3, 7, 11);
        quarter_mix(0, 1, 2, 3);
        quarter_mix(5, 6, 7, 4);
        quarter_mix(10, 11, 8, 9);
        quarter_mix(15, 12, 13, 14);
      end
      // feed-forward, word i lands in bits 32i up
      for (int i = 0; i < 16; i++) begin
        packed_words[32*i +: 32] = mix_words[i] + seed[i];
      end
      return packed_words;
    endfunction

    function void write_reg(logic [salsa_kg_pkg::CFG_IDX_W-1:0] index,
                            logic [salsa_kg_pkg::CFG_W-1:0] value);
      if (index == salsa_kg_pkg::REG_DROUNDS) begin
        reg_file[index] = {{(salsa_kg_pkg::CFG_W-salsa_kg_pkg::DR_W){1'b0}},
                           value[salsa_kg_pkg::DR_W-1:0]};
      end else begin
        reg_file[index] = value;
      end
    endfunction

    function void note_request(logic kind, logic [63:0] value);
      keystream_block_t blk;
      if (kind == salsa_kg_pkg::KIND_SET_CTR) begin
        block_counter = value;
        counter_loads++;
      end else begin
        for (int b = 0; b < BLOCKS; b++) begin
          blk.data = keystream_block(block_counter + 64'(b));
          blk.last = (b == BLOCKS - 1);
          pending_blocks.push_back(blk);
        end
        block_counter += 64'(BLOCKS);
        requests++;
      end
    endfunction

    function void check_block(logic [511:0] data, logic last);
      keystream_block_t want;
      if (pending_blocks.size() == 0) begin
        $error("keystream block transfer with no request pending: %h", data);
        errors++;
        return;
      end
      want = pending_blocks.pop_front();
      blocks_checked++;
      for (int j = 0; j < 8; j++) begin
        if (data[64*j +: 64] !== want.data[64*j +: 64]) begin
          $error("block_bytes_%0d mismatch: expected %h, actual %h",
                 j, want.data[64*j +: 64], data[64*j +: 64]);
          errors++;
        end
      end
      if (last !== want.last) begin
        $error("last_block mismatch: expected %b, actual %b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                                 clk;
  logic                                 rst_n;
  logic                                 cfg_wr_en;
  logic [salsa_kg_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [salsa_kg_pkg::CFG_W-1:0]       cfg_wdata;
  logic                                 in_tvalid;
  logic                                 in_tready;
  logic [63:0]                          in_tdata;   // counter_value
  logic                                 in_tuser;   // kind
  logic                                 out_tvalid;
  logic                                 out_tready;
  logic [511:0]                         out_tdata;  // block_bytes_0 .. block_bytes_7
  logic                                 out_tlast;  // last_block

  keystream_scoreboard sb;
  bit send_quiet;
  bit take_quiet;
  int settings_applied;

  salsa20_keystream_generator #(
    .BLOCKS_PER_REQUEST(BLOCKS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // every transfer is sampled here, at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) begin
        sb.write_reg(cfg_index, cfg_wdata);
      end
      if (in_tvalid && in_tready) begin
        sb.note_request(in_tuser, in_tdata);
      end
      if (out_tvalid && out_tready) begin
        sb.check_block(out_tdata, out_tlast);
      end
    end
  end

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // receiver: random stall before each block
  initial begin
    int stall;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = take_quiet ? 0 : draw_gap();
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!(out_tvalid === 1'b1 && rst_n === 1'b1));
      @(negedge clk);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  task automatic send_item(input logic kind, input logic [63:0] value);
    int gap;
    gap = send_quiet ? 0 : draw_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = value;
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic wait_for_blocks();
    in_tvalid = 1'b0;
    while (sb.pending_blocks.size() != 0) @(negedge clk);
  endtask

  // a counter load may still be in work after the last block
  task automatic settle();
    wait_for_blocks();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic drive_reg_write(input logic [salsa_kg_pkg::CFG_IDX_W-1:0] index,
                                 input logic [salsa_kg_pkg::CFG_W-1:0] value);
    cfg_wr_en = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic apply_settings(input logic [63:0] ca, input logic [63:0] cb,
                                input logic [63:0] ka, input logic [63:0] kb,
                                input logic [63:0] kc, input logic [63:0] kd,
                                input logic [63:0] nonce, input logic [3:0] rounds);
    logic [63:0] spare;
    spare = rand64();
    drive_reg_write(salsa_kg_pkg::REG_CONST_A, ca);
    drive_reg_write(salsa_kg_pkg::REG_CONST_B, cb);
    drive_reg_write(salsa_kg_pkg::REG_KEY_A, ka);
    drive_reg_write(salsa_kg_pkg::REG_KEY_B, kb);
    drive_reg_write(salsa_kg_pkg::REG_KEY_C, kc);
    drive_reg_write(salsa_kg_pkg::REG_KEY_D, kd);
    drive_reg_write(salsa_kg_pkg::REG_NONCE, nonce);
    // upper bits are don't-care in the round count register
    drive_reg_write(salsa_kg_pkg::REG_DROUNDS, {spare[63:4], rounds});
    settings_applied++;
  endtask

  task automatic run_traffic(input int items);
    logic [63:0] value;
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(0, 99) < 62) begin
        send_item(salsa_kg_pkg::KIND_GENERATE, rand64());
      end else begin
        case ($urandom_range(0, 3))
          0: value = {32'hFFFFFFFF, 29'h1FFFFFFF, 3'($urandom_range(0, 7))};
          1: value = {$urandom, 28'hFFFFFFF, 4'($urandom_range(0, 15))};
          default: value = rand64();
        endcase
        send_item(salsa_kg_pkg::KIND_SET_CTR, value);
      end
      if ($urandom_range(0, 24) == 0) begin
        wait_for_blocks();
      end
    end
  endtask

  initial begin
    logic [3:0] round_plan [PHASES];
    logic [63:0] ca;
    logic [63:0] cb;
    sb = new();
    send_quiet = 1'b0;
    take_quiet = 1'b0;
    settings_applied = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = salsa_kg_pkg::REG_CONST_A;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tuser = salsa_kg_pkg::KIND_GENERATE;
    in_tdata = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: zero matrix, ten double rounds
    send_item(salsa_kg_pkg::KIND_GENERATE, '1);
    send_item(salsa_kg_pkg::KIND_SET_CTR, 64'hFFFFFFFF_FFFFFFFE);
    send_item(salsa_kg_pkg::KIND_GENERATE, '0);
    send_item(salsa_kg_pkg::KIND_GENERATE, rand64());
    send_item(salsa_kg_pkg::KIND_SET_CTR, 64'h00000000_FFFFFFFE);
    send_item(salsa_kg_pkg::KIND_GENERATE, rand64());
    send_item(salsa_kg_pkg::KIND_SET_CTR, '0);
    send_item(salsa_kg_pkg::KIND_SET_CTR, '1);
    send_item(salsa_kg_pkg::KIND_GENERATE, rand64());
    settle();

    // zero double rounds: each word comes out doubled
    apply_settings(SIGMA_A, SIGMA_B, rand64(), rand64(), rand64(), rand64(), rand64(), 4'd0);
    send_item(salsa_kg_pkg::KIND_SET_CTR, 64'hFFFFFFFF_FFFFFFFC);
    send_item(salsa_kg_pkg::KIND_GENERATE, rand64());
    send_item(salsa_kg_pkg::KIND_GENERATE, rand64());
    settle();

    apply_settings('1, '1, '1, '1, '1, '1, '1, 4'd15);
    send_item(salsa_kg_pkg::KIND_GENERATE, rand64());
    send_item(salsa_kg_pkg::KIND_SET_CTR, 64'h55555555_AAAAAAAA);
    send_item(salsa_kg_pkg::KIND_GENERATE, rand64());
    settle();

    round_plan = '{4'd1, 4'd10, 4'd0, 4'd15, 4'd11, 4'd6, 4'd10};
    round_plan[5] = 4'($urandom_range(2, 9));
    for (int p = 0; p < PHASES; p++) begin
      ca = (p % 2 == 0) ? SIGMA_A : rand64();
      cb = (p % 2 == 0) ? SIGMA_B : rand64();
      if (p == 1) begin
        apply_settings('1, '1, '1, '1, '1, '1, '1, round_plan[p]);
      end else if (p == 4) begin
        apply_settings('0, '0, '0, '0, '0, '0, '0, round_plan[p]);
      end else begin
        apply_settings(ca, cb, rand64(), rand64(), rand64(), rand64(), rand64(),
                       round_plan[p]);
      end
      send_quiet = (p == 2) || (p == 5);
      take_quiet = (p == 3) || (p == 5);
      run_traffic(PHASE_ITEMS);
      settle();
    end

    wait_for_blocks();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("covered %0d generate requests (%0d blocks checked) and %0d counter loads",
             sb.requests, sb.blocks_checked, sb.counter_loads);
    $display("over %0d register settings, double rounds 0, 1, 10, 11 and 15 among them",
             settings_applied);
    if (sb.errors == 0 && sb.pending_blocks.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
